FILE: sv/srtlen_pkg.sv
// shared types and constants for the length sorter
// item structs for the request and response channels, sequencer states
// no dependencies
`default_nettype none

package srtlen_pkg;

   localparam int DEF_MAX_RECORDS = 64;
   localparam int DEF_KEY_BITS    = 16;
   localparam int LEN_W           = 16;
   localparam int IDX_W           = 6;

   typedef struct packed {
      logic [LEN_W-1:0] word_length;
      logic             last_item;
   } req_type;

   typedef struct packed {
      logic [LEN_W-1:0] sorted_length;
      logic [IDX_W-1:0] record_index;
      logic             last_result;
      logic             overflow;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SHIFT,
      ST_PLACE,
      ST_EMIT_RD,
      ST_EMIT_WAIT
   } state_type;

endpackage

`default_nettype wire

FILE: sv/srtlen_outreg.sv
// one-entry output register for the response channel
// takes an item when ready is high and holds it until downstream stops stalling
// depends on srtlen_pkg
`default_nettype none

module srtlen_outreg (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                load,
   input  wire srtlen_pkg::rsp_type load_data,
   output logic                     ready,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output srtlen_pkg::rsp_type      rsp_data
);
   import srtlen_pkg::*;

   logic    valid_ff;
   logic    valid_in;
   rsp_type data_ff;

   // free when empty or when the held item leaves this cycle
   assign ready     = !valid_ff || !rsp_stall;
   assign valid_in  = (ready) ? load : valid_ff;
   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ready && load) begin
         data_ff <= load_data;
      end
   end

endmodule

`default_nettype wire

FILE: sv/sort_records_by_length_unit.sv
// stable ascending sort of a set of records by length, with arrival index
// insertion sort over one sorted key/index memory, then readout in order
// depends on srtlen_pkg, srtlen_outreg
//
//   port group  | dir | handshake           | payload
//   req_*       | in  | req_valid/req_stall | req_type: word_length, last_item
//   rsp_*       | out | rsp_valid/rsp_stall | rsp_type: sorted_length, record_index,
//               |     |                     |           last_result, overflow
//
// an item is taken only in the idle state; insertion walks down the sorted memory
// one entry per cycle, moving each entry with a larger key up by one;
// a dropped item goes straight back to idle, or to readout if it was the last
// after the last item each result is read from memory, then loaded into the output
// register; readout waits while rsp_stall holds the output register
// synchronous reset empties the set; memory contents are not cleared
`default_nettype none

module sort_records_by_length_unit #(
   parameter int MAX_RECORDS = srtlen_pkg::DEF_MAX_RECORDS,
   parameter int KEY_BITS    = srtlen_pkg::DEF_KEY_BITS
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire srtlen_pkg::req_type req_data,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output srtlen_pkg::rsp_type      rsp_data
);
   import srtlen_pkg::*;

   localparam int ADDR_W = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
   localparam int CNT_W  = $clog2(MAX_RECORDS + 1);
   localparam int ENT_W  = KEY_BITS + ADDR_W;

   // sorted store: key in the upper bits, arrival index in the lower bits
   logic [ENT_W-1:0] mem [MAX_RECORDS];
   logic [ENT_W-1:0] rd_data_ff;
   logic [ADDR_W-1:0] rd_addr;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [ENT_W-1:0]  wr_data;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  fill_ff, fill_in;
   logic              ovf_ff, ovf_in;
   logic              last_ff, last_in;
   logic [ADDR_W-1:0] pos_ff, pos_in;
   logic [KEY_BITS-1:0] key_ff, key_in;
   logic [ADDR_W-1:0] idx_ff, idx_in;
   logic [ADDR_W-1:0] emit_ff, emit_in;

   logic                accept;
   logic [KEY_BITS-1:0] req_key;
   logic                has_room;
   logic [KEY_BITS-1:0] rd_key;
   logic [ADDR_W-1:0]   rd_idx;
   logic                bigger;
   logic                emit_last;
   logic                out_ready;
   logic                out_load;
   rsp_type             out_data;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign req_key   = KEY_BITS'(req_data.word_length);
   assign has_room  = (fill_ff < CNT_W'(MAX_RECORDS));
   assign rd_key    = rd_data_ff[ENT_W-1 -: KEY_BITS];
   assign rd_idx    = rd_data_ff[ADDR_W-1:0];
   assign bigger    = (rd_key > key_ff);
   assign emit_last = ((CNT_W'(emit_ff) + CNT_W'(1)) == fill_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (!has_room) begin
                  state_in = (req_data.last_item) ? ST_EMIT_RD : ST_IDLE;
               end else if (fill_ff == '0) begin
                  state_in = ST_PLACE;
               end else begin
                  state_in = ST_SHIFT;
               end
            end
         end
         ST_SHIFT: begin
            if (!bigger) begin
               state_in = (last_ff) ? ST_EMIT_RD : ST_IDLE;
            end else if (pos_ff == ADDR_W'(1)) begin
               state_in = ST_PLACE;
            end
         end
         ST_PLACE: begin
            state_in = (last_ff) ? ST_EMIT_RD : ST_IDLE;
         end
         ST_EMIT_RD: begin
            state_in = ST_EMIT_WAIT;
         end
         ST_EMIT_WAIT: begin
            if (out_ready) begin
               state_in = (emit_last) ? ST_IDLE : ST_EMIT_RD;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath control
   always_comb begin
      fill_in  = fill_ff;
      ovf_in   = ovf_ff;
      last_in  = last_ff;
      pos_in   = pos_ff;
      key_in   = key_ff;
      idx_in   = idx_ff;
      emit_in  = emit_ff;
      rd_addr  = emit_ff;
      wr_en    = 1'b0;
      wr_addr  = pos_ff;
      wr_data  = {key_ff, idx_ff};
      out_load = 1'b0;
      out_data.sorted_length = LEN_W'(rd_key);
      out_data.record_index  = IDX_W'(rd_idx);
      out_data.last_result   = emit_last;
      out_data.overflow      = ovf_ff;
      unique case (state_ff)
         ST_IDLE: begin
            rd_addr = ADDR_W'(fill_ff - CNT_W'(1));
            emit_in = '0;
            if (accept) begin
               last_in = req_data.last_item;
               key_in  = req_key;
               idx_in  = ADDR_W'(fill_ff);
               pos_in  = ADDR_W'(fill_ff);
               if (!has_room) begin
                  ovf_in = 1'b1;
               end
            end
         end
         ST_SHIFT: begin
            // read two below while the entry one below moves up
            rd_addr = pos_ff - ADDR_W'(2);
            wr_en   = 1'b1;
            if (bigger) begin
               wr_data = rd_data_ff;
               pos_in  = pos_ff - ADDR_W'(1);
            end else begin
               fill_in = fill_ff + CNT_W'(1);
            end
         end
         ST_PLACE: begin
            wr_en   = 1'b1;
            fill_in = fill_ff + CNT_W'(1);
         end
         ST_EMIT_RD: begin
            rd_addr = emit_ff;
         end
         ST_EMIT_WAIT: begin
            rd_addr  = emit_ff;
            out_load = 1'b1;
            if (out_ready) begin
               if (emit_last) begin
                  fill_in = '0;
                  ovf_in  = 1'b0;
               end else begin
                  emit_in = emit_ff + ADDR_W'(1);
               end
            end
         end
         default: begin
            rd_addr = emit_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fill_ff  <= '0;
         ovf_ff   <= 1'b0;
         last_ff  <= 1'b0;
         emit_ff  <= '0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         ovf_ff   <= ovf_in;
         last_ff  <= last_in;
         emit_ff  <= emit_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff <= pos_in;
      key_ff <= key_in;
      idx_ff <= idx_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   srtlen_outreg u_outreg (
      .clock     (clock),
      .reset     (reset),
      .load      (out_load),
      .load_data (out_data),
      .ready     (out_ready),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

FILE: sim/sort_order_checker.sv
`timescale 1ns / 1ps
// checker for sort_records_by_length_unit: watches the req and rsp channels,
// predicts each set's sorted output and compares it result by result
// depends on srtlen_pkg
module sort_order_checker #(
   parameter int MAX_RECORDS = srtlen_pkg::DEF_MAX_RECORDS,
   parameter int KEY_BITS    = srtlen_pkg::DEF_KEY_BITS
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   input  wire logic          req_stall,
   input  srtlen_pkg::req_type req_data,
   input  wire logic          rsp_valid,
   input  wire logic          rsp_stall,
   input  srtlen_pkg::rsp_type rsp_data,
   output int                 errors,
   output int                 results_due,
   output int                 results_seen
);
   import srtlen_pkg::*;

   localparam logic [LEN_W-1:0] KEY_MASK =
      (KEY_BITS >= LEN_W) ? '1 : LEN_W'((1 << KEY_BITS) - 1);
   localparam int MAX_PRINTED = 30;

   // sorted store of the set being collected
   logic [LEN_W-1:0] stored_keys [MAX_RECORDS];
   logic [IDX_W-1:0] stored_index [MAX_RECORDS];
   int               held_records = 0;
   bit               records_dropped = 1'b0;

   rsp_type sorted_results_due [$];
   int      mismatch_total = 0;
   int      result_total = 0;

   assign errors = mismatch_total;

   task automatic report_error(input string msg);
      if (mismatch_total < MAX_PRINTED)
         $display("ERROR at %0t: %s", $realtime, msg);
      mismatch_total++;
   endtask

   task automatic check_field(input string field, input int unsigned want,
                              input int unsigned got);
      if (want != got)
         report_error($sformatf("result %0d %s: expected %0d, got %0d",
                                result_total, field, want, got));
   endtask

   // stable insertion: a new key goes after every stored key not greater than it
   task automatic insert_sorted(input req_type rec);
      logic [LEN_W-1:0] key;
      int               pos;
      rsp_type          res;
      key = rec.word_length & KEY_MASK;
      if (held_records < MAX_RECORDS) begin
         pos = held_records;
         while (pos > 0 && stored_keys[pos-1] > key) begin
            stored_keys[pos]  = stored_keys[pos-1];
            stored_index[pos] = stored_index[pos-1];
            pos--;
         end
         stored_keys[pos]  = key;
         stored_index[pos] = IDX_W'(held_records);
         held_records++;
      end else begin
         records_dropped = 1'b1;
      end
      if (rec.last_item) begin
         for (int k = 0; k < held_records; k++) begin
            res.sorted_length = stored_keys[k];
            res.record_index  = stored_index[k];
            res.last_result   = (k == held_records - 1);
            res.overflow      = records_dropped;
            sorted_results_due.push_back(res);
         end
         held_records    = 0;
         records_dropped = 1'b0;
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         held_records    = 0;
         records_dropped = 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (sorted_results_due.size() == 0) begin
               report_error($sformatf("unexpected result: length %0d index %0d",
                                      rsp_data.sorted_length, rsp_data.record_index));
            end else begin
               want = sorted_results_due.pop_front();
               check_field("sorted_length", want.sorted_length, rsp_data.sorted_length);
               check_field("record_index", want.record_index, rsp_data.record_index);
               check_field("last_result", want.last_result, rsp_data.last_result);
               check_field("overflow", want.overflow, rsp_data.overflow);
            end
            result_total++;
         end
         if (req_valid && !req_stall)
            insert_sorted(req_data);
      end
      results_due  <= sorted_results_due.size();
      results_seen <= result_total;
   end

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps
// top of the length sorter testbench: clock, reset, record stimulus, output stall
// and verdict; depends on srtlen_pkg, sort_records_by_length_unit, sort_order_checker
module testbench;
   import srtlen_pkg::*;

   localparam int LIMIT        = 300000;
   localparam int RANDOM_ITEMS = 430;
   localparam int LONG_HOLD    = 600;
   localparam int DRAIN_CYCLES = 60;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b1;
   rsp_type rsp_data;

   int errors;
   int results_due;
   int results_seen;
   int cycle_count = 0;
   int send_run = 0;
   int take_run = 0;
   int random_sent = 0;

   always #4 clock = ~clock;

   sort_records_by_length_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   sort_order_checker u_check (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data),
      .errors       (errors),
      .results_due  (results_due),
      .results_seen (results_seen)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("== FAIL ==");
         $finish;
      end
   end

   // idle cycles before the next item, with occasional back-to-back runs
   function automatic int draw_gap(inout int run_left);
      if (run_left > 0) begin
         run_left--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) begin
         run_left = $urandom_range(10, 40);
         return 0;
      end
      return $urandom_range(0, 3);
   endfunction

   function automatic logic [LEN_W-1:0] draw_length(input int style);
      case (style)
         0: return LEN_W'($urandom_range(0, 7));
         1: return $urandom_range(0, 1) ? '1 : '0;
         default: return LEN_W'($urandom);
      endcase
   endfunction

   task automatic send_record(input logic [LEN_W-1:0] len, input logic last);
      int gap;
      gap = draw_gap(send_run);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= req_type'({len, last});
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic send_set(input logic [LEN_W-1:0] lens[$]);
      foreach (lens[i]) send_record(lens[i], i == lens.size() - 1);
   endtask

   initial begin
      int set_no;
      int set_size;
      int style;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed sets: lone record, extremes with ties, all equal, descending, bit patterns
      send_set('{16'h0000});
      send_set('{16'hFFFF, 16'h0000, 16'hFFFF, 16'h0001, 16'h8000});
      send_set('{16'd5, 16'd5, 16'd5, 16'd5});
      send_set('{16'd9, 16'd8, 16'd7, 16'd6, 16'd5, 16'd4, 16'd3, 16'd2, 16'd1, 16'd0});
      send_set('{16'h5555, 16'hAAAA, 16'h00FF, 16'hFF00});

      set_no = 0;
      while (random_sent < RANDOM_ITEMS) begin
         if (set_no == 1)
            set_size = 64;                    // exactly full
         else if (set_no == 3)
            set_size = 66;                    // last record itself dropped
         else if ($urandom_range(0, 24) == 0)
            set_size = $urandom_range(60, 70);
         else
            set_size = $urandom_range(1, 12);
         style = $urandom_range(0, 3);
         for (int i = 0; i < set_size; i++)
            send_record(draw_length(style), i == set_size - 1);
         random_sent += set_size;
         set_no++;
      end
      req_valid <= 1'b0;

      @(posedge clock);
      while (results_due != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   // output side: random stalls, plus one long hold-off so the block backs up
   initial begin
      int  gap;
      bit  held_off;
      held_off = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (!held_off && results_seen >= 20) begin
            gap      = LONG_HOLD;
            held_off = 1'b1;
         end else begin
            gap = draw_gap(take_run);
         end
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

endmodule

FILE: sort_records_by_length_unit.f
sv/srtlen_pkg.sv
sv/srtlen_outreg.sv
sv/sort_records_by_length_unit.sv
sim/sort_order_checker.sv
sim/testbench.sv
